[rtl/core/scfr_pkg.sv]
`timescale 1ns / 1ps

package scfr_pkg;

  // Width of the slot field on both streams
  localparam int SLOT_FIELD_W = 6;

  // Defaults for the top-level parameters
  localparam int FRAMES_DEFAULT    = 64;
  localparam int PAGE_BITS_DEFAULT = 36;

  // Command codes carried on s_tuser
  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_CLAIM = 1'b1;

endpackage

[rtl/core/scfr_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module scfr_ram #(
  parameter int DEPTH = scfr_pkg::FRAMES_DEFAULT,
  parameter int WIDTH = scfr_pkg::PAGE_BITS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/second_chance_frame_replacer.sv]
`timescale 1ns / 1ps

// Second-chance (clock) frame table with FRAMES slots.
// Input stream s_*: s_tuser is the command (touch or claim), s_tdata holds
// touch_slot and page_number. Output stream m_*: one beat per input beat,
// m_tuser is the evicted flag, m_tdata holds granted_slot and evicted_page.
// Slots fill in order 0, 1, 2, ...; once full, a claim walks the hand,
// clearing referenced bits, and replaces the first unreferenced slot.
// Timing: a touch, or a claim while free slots remain, goes from S_IDLE
// to S_DONE, which loads the output register and returns to S_IDLE, where
// the next beat can be taken. A claim on a full table first passes through
// S_CHECK, passing over the referenced slots (at most FRAMES) until it
// finds an unreferenced one. The walk tests one slot a cycle, set by the
// single read port of the referenced-bit memory.
// s_tready is high whenever no item is in work, also while a finished
// result waits on m_*. A stalled receiver holds the output register; a
// finished item then waits until it frees, and no new beat is taken.
// Reset (rst, synchronous) empties the table and parks the hand on slot 0;
// no clearing pass is needed, the fill count marks which slots hold pages.
module second_chance_frame_replacer #(
  parameter int FRAMES    = scfr_pkg::FRAMES_DEFAULT,
  parameter int PAGE_BITS = scfr_pkg::PAGE_BITS_DEFAULT,
  localparam int DATA_W   = ((scfr_pkg::SLOT_FIELD_W + PAGE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // slave side
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // touch_slot, page_number, zero fill
  input  logic              s_tuser,  // cmd
  // master side
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,  // granted_slot, evicted_page, zero fill
  output logic              m_tuser   // evicted
);

  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int SW = scfr_pkg::SLOT_FIELD_W;

  typedef enum logic [1:0] {S_IDLE, S_CHECK, S_DONE} state_t;

  state_t                 state;
  logic [IW-1:0]          hand;
  logic [CW-1:0]          fill_count;
  logic [PAGE_BITS-1:0]   pg;
  logic [SW-1:0]          res_slot;
  logic                   res_evicted;
  logic [PAGE_BITS-1:0]   res_page;

  logic                   in_beat;
  logic                   is_claim;
  logic                   full;
  logic                   occupied;
  logic [SW-1:0]          in_slot;
  logic [PAGE_BITS-1:0]   in_page;
  logic [31:0]            touch32;
  logic [IW-1:0]          touch_idx;
  logic [IW-1:0]          fill_idx;
  logic [IW-1:0]          hand_next;
  logic [31:0]            fill32;
  logic [31:0]            hand32;
  logic [SW-1:0]          fill_slot;
  logic [SW-1:0]          hand_slot;

  logic                   page_we;
  logic [IW-1:0]          page_waddr;
  logic [PAGE_BITS-1:0]   page_wdata;
  logic [PAGE_BITS-1:0]   page_rd;
  logic                   ref_we;
  logic [IW-1:0]          ref_waddr;
  logic [0:0]             ref_wdata;
  logic [0:0]             ref_rd;
  logic [IW-1:0]          raddr;

  // input decode
  assign s_tready  = (state == S_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign is_claim  = (s_tuser == scfr_pkg::CMD_CLAIM);
  assign in_slot   = s_tdata[SW-1:0];
  assign in_page   = s_tdata[SW+PAGE_BITS-1:SW];
  assign touch32   = 32'(in_slot);
  assign touch_idx = touch32[IW-1:0];
  assign full      = (fill_count == CW'(FRAMES));
  // slots fill in order, so a slot holds a page exactly when it is below the count
  assign occupied  = (touch32 < 32'(fill_count));
  assign fill_idx  = fill_count[IW-1:0];

  // shared hand step with wrap
  assign hand_next = (hand == IW'(FRAMES - 1)) ? '0 : hand + 1'b1;

  // slot indexes onto the 6-bit result field
  assign fill32    = 32'(fill_idx);
  assign hand32    = 32'(hand);
  assign fill_slot = fill32[SW-1:0];
  assign hand_slot = hand32[SW-1:0];

  // memory port control
  always_comb begin
    page_we    = 1'b0;
    page_waddr = fill_idx;
    page_wdata = in_page;
    ref_we     = 1'b0;
    ref_waddr  = fill_idx;
    ref_wdata  = 1'b0;
    raddr      = hand;
    case (state)
      S_IDLE: begin
        if (in_beat && is_claim && !full) begin
          page_we = 1'b1;
          ref_we  = 1'b1;
        end else if (in_beat && !is_claim && occupied) begin
          ref_we    = 1'b1;
          ref_waddr = touch_idx;
          ref_wdata = 1'b1;
        end
      end
      S_CHECK: begin
        ref_we     = 1'b1;
        ref_waddr  = hand;
        page_waddr = hand;
        page_wdata = pg;
        page_we    = !ref_rd[0];
        if (ref_rd[0]) begin
          raddr = hand_next;
        end
      end
      default: begin
      end
    endcase
  end

  scfr_ram #(
    .DEPTH(FRAMES),
    .WIDTH(PAGE_BITS)
  ) u_page_ram (
    .clk  (clk),
    .we   (page_we),
    .waddr(page_waddr),
    .wdata(page_wdata),
    .raddr(raddr),
    .rdata(page_rd)
  );

  scfr_ram #(
    .DEPTH(FRAMES),
    .WIDTH(1)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(ref_waddr),
    .wdata(ref_wdata),
    .raddr(raddr),
    .rdata(ref_rd)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hand       <= '0;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // output register drains unless a new result loads it this cycle
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            res_slot    <= '0;
            res_evicted <= 1'b0;
            res_page    <= '0;
            pg          <= in_page;
            if (!is_claim) begin
              state <= S_DONE;
            end else if (!full) begin
              res_slot   <= fill_slot;
              fill_count <= fill_count + 1'b1;
              state      <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          hand <= hand_next;
          if (!ref_rd[0]) begin
            res_slot    <= hand_slot;
            res_evicted <= 1'b1;
            res_page    <= page_rd;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= DATA_W'({res_page, res_slot});
            m_tuser  <= res_evicted;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(FRAMES))
    else $error("fill count beyond table size");

  // the hand walks only over a full table
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> full)
    else $error("sweep on a table that is not full");

  // a claim on a table with free slots takes exactly one more slot
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (in_beat && is_claim && !full) |=> (fill_count == $past(fill_count) + 1'b1))
    else $error("fill count did not step on claim");

  // the hand moves only while sweeping
  a_hand_still: assert property (@(posedge clk) disable iff (rst)
    (state != S_CHECK) |=> $stable(hand))
    else $error("hand moved outside a sweep");

  // a finished item reaches the output once the register is free
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == S_IDLE))
    else $error("finished result not delivered");

endmodule
